// ----- rtl/core/pud_pkg.sv -----
// Shared types, byte constants and hex helpers for the percent and UTF-8 decoder.
package pud_pkg;

	localparam int CP_W = 21;
	localparam int MAX_RES = 4;
	localparam int HELD_N = 3;

	localparam logic [7:0] BYTE_PCT = 8'h25;
	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] MASK_F0 = 8'hF0;
	localparam logic [7:0] MASK_F8 = 8'hF8;
	localparam logic [7:0] MASK_C0 = 8'hC0;
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT = 8'h80;
	localparam logic [7:0] LOW6 = 8'h3F;
	localparam logic [7:0] LOW5 = 8'h1F;
	localparam logic [7:0] LOW4 = 8'h0F;
	localparam logic [7:0] LOW3 = 8'h07;
	localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;

	// One result item before it goes to the output port
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic raw;
		logic err;
	} pud_res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if (is_hex(c)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/percent_and_utf8_decoder.sv -----
// Top level: percent-escape and UTF-8 decoder, one byte in, up to four code points out.
//
// channel | dir | tdata                               | tuser                       | tlast
// s_*     | in  | [7:0] in_byte                       | -                           | token_end
// m_*     | out | [20:0] code_point, [21] run_last    | [0] passed_raw,             | token_last
//         |     | (zero filled to 24 bits)            | [1] escape_error            |
//
// An input byte is decoded in the cycle it is accepted and its results land in a
// four-entry result buffer. The buffer drains one result per cycle while m_tready is high;
// bytes with one or no result go at one per cycle while m_tready is high.
// s_tready is high while the buffer is empty or its last result is being taken.
// arst_n clears the decode state and empties the buffer. Held bytes need no reset.
module percent_and_utf8_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // token_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [21] run_last, [23:22] zero
	output logic [1:0]  m_tuser,   // [0] passed_raw, [1] escape_error
	output logic        m_tlast    // token_last
);
	import pud_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PCT,
		MODE_UTF
	} mode_t;

	// decode state
	mode_t mode_q, mode_d;
	logic [7:0] held_q [HELD_N];
	logic [7:0] held_d [HELD_N];
	logic [1:0] hcnt_q, hcnt_d;
	logic [1:0] need_q, need_d;
	logic [CP_W-1:0] part_q, part_d, part_nx;

	// result buffer
	pud_res_t res_q [MAX_RES];
	pud_res_t list [MAX_RES];
	pud_res_t one_res;
	logic [2:0] n;
	logic [2:0] rem_q;
	logic [1:0] idx_q;
	logic end_q;

	logic in_fire, out_fire;
	logic fresh, flush_a, emit_one;
	logic [7:0] b;
	logic [7:0] pct_v;

	assign b = s_tdata;
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);

	// decode one byte into next state and a list of results
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		hcnt_d = hcnt_q;
		need_d = need_q;
		part_d = part_q;
		fresh = 1'b1;
		flush_a = 1'b0;
		emit_one = 1'b0;
		one_res = '0;
		n = 3'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			list[i] = '0;
		end
		part_nx = {part_q[CP_W-7:0], b[5:0]};
		pct_v = {hex_val(held_q[1]), hex_val(b)};

		// continue a pending escape or sequence
		case (mode_q)
			MODE_PCT: begin
				if (is_hex(b)) begin
					fresh = 1'b0;
					if (hcnt_q < 2'd2) begin
						held_d[1] = b;
						hcnt_d = 2'd2;
					end else begin
						emit_one = 1'b1;
						one_res = '{cp: {13'd0, pct_v}, raw: 1'b0, err: pct_v[7]};
						mode_d = MODE_IDLE;
						hcnt_d = 2'd0;
						need_d = 2'd0;
						part_d = '0;
					end
				end else begin
					flush_a = 1'b1;
				end
			end
			MODE_UTF: begin
				if ((b & MASK_C0) == CONT && need_q != 2'd0) begin
					fresh = 1'b0;
					part_d = part_nx;
					need_d = need_q - 2'd1;
					if (need_q == 2'd1) begin
						emit_one = 1'b1;
						if (part_nx > CP_LIMIT) begin
							flush_a = 1'b1;
							one_res = '{cp: {13'd0, b}, raw: 1'b1, err: 1'b0};
						end else begin
							one_res = '{cp: part_nx, raw: 1'b0, err: 1'b0};
							mode_d = MODE_IDLE;
							hcnt_d = 2'd0;
							need_d = 2'd0;
							part_d = '0;
						end
					end else if (hcnt_q < 2'd3) begin
						held_d[hcnt_q] = b;
						hcnt_d = hcnt_q + 2'd1;
					end
				end else begin
					flush_a = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				hcnt_d = 2'd0;
				need_d = 2'd0;
				part_d = '0;
			end
		endcase

		// flush held bytes of a broken run
		if (flush_a) begin
			for (int i = 0; i < HELD_N; i++) begin
				if (2'(i) < hcnt_q && n < 3'd4) begin
					list[n[1:0]] = '{cp: {13'd0, held_q[i]}, raw: 1'b1, err: 1'b0};
					n = n + 3'd1;
				end
			end
			mode_d = MODE_IDLE;
			hcnt_d = 2'd0;
			need_d = 2'd0;
			part_d = '0;
		end
		if (emit_one && n < 3'd4) begin
			list[n[1:0]] = one_res;
			n = n + 3'd1;
		end

		// decode the byte as if idle
		if (fresh) begin
			if (b == BYTE_PCT) begin
				mode_d = MODE_PCT;
				held_d[0] = b;
				hcnt_d = 2'd1;
			end else if (b < CONT) begin
				if (n < 3'd4) begin
					list[n[1:0]] = '{cp: {13'd0, b}, raw: 1'b0, err: 1'b0};
					n = n + 3'd1;
				end
			end else if ((b & MASK_E0) == LEAD2) begin
				mode_d = MODE_UTF;
				held_d[0] = b;
				hcnt_d = 2'd1;
				need_d = 2'd1;
				part_d = {13'd0, b & LOW5};
			end else if ((b & MASK_F0) == LEAD3) begin
				mode_d = MODE_UTF;
				held_d[0] = b;
				hcnt_d = 2'd1;
				need_d = 2'd2;
				part_d = {13'd0, b & LOW4};
			end else if ((b & MASK_F8) == LEAD4) begin
				mode_d = MODE_UTF;
				held_d[0] = b;
				hcnt_d = 2'd1;
				need_d = 2'd3;
				part_d = {13'd0, b & LOW3};
			end else if (n < 3'd4) begin
				list[n[1:0]] = '{cp: {13'd0, b}, raw: 1'b1, err: 1'b0};
				n = n + 3'd1;
			end
		end

		// end of token: flush what is still pending
		if (s_tlast) begin
			if (mode_d != MODE_IDLE) begin
				for (int i = 0; i < HELD_N; i++) begin
					if (2'(i) < hcnt_d && n < 3'd4) begin
						list[n[1:0]] = '{cp: {13'd0, held_d[i]}, raw: 1'b1, err: 1'b0};
						n = n + 3'd1;
					end
				end
			end
			mode_d = MODE_IDLE;
			hcnt_d = 2'd0;
			need_d = 2'd0;
			part_d = '0;
		end
	end

	// control state: decode mode, counters and buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hcnt_q <= 2'd0;
			need_q <= 2'd0;
			part_q <= '0;
			rem_q <= 3'd0;
			idx_q <= 2'd0;
			end_q <= 1'b0;
		end else begin
			if (in_fire) begin
				mode_q <= mode_d;
				hcnt_q <= hcnt_d;
				need_q <= need_d;
				part_q <= part_d;
				rem_q <= n;
				idx_q <= 2'd0;
				end_q <= s_tlast;
			end else if (out_fire) begin
				rem_q <= rem_q - 3'd1;
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// payload: held bytes and buffered results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= held_d;
			res_q <= list;
		end
	end

	// drive the output item from the buffer
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata = {2'b00, (rem_q == 3'd1), res_q[idx_q].cp};
	assign m_tuser = {res_q[idx_q].err, res_q[idx_q].raw};
	assign m_tlast = (rem_q == 3'd1) && end_q;

	// no new byte while more than one result waits
	assert property (@(posedge clk) disable iff (!arst_n) rem_q > 3'd1 |-> !s_tready)
		else $error("input taken while results still queued");

	// a byte with results shows its first result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) in_fire && n != 3'd0 |=> m_tvalid)
		else $error("results of accepted byte not presented");

	// idle decoder holds nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> hcnt_q == 2'd0 && need_q == 2'd0)
		else $error("idle decoder with pending bytes");

	// an escape result is never a passed-through byte
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("raw and escape error flags both set");

endmodule
